@@ rtl/core/pfde_pkg.sv @@
package pfde_pkg;

  localparam int unsigned ScreenWidth  = 128;
  localparam int unsigned ScreenHeight = 64;
  localparam int unsigned PageCount    = ScreenHeight / 8;
  localparam int unsigned StoreSize    = (PageCount + 1) * ScreenWidth;
  localparam int unsigned AddrW        = $clog2(StoreSize);
  localparam int unsigned ColW         = $clog2(ScreenWidth);
  localparam int unsigned PageW        = $clog2(PageCount + 1);

  localparam logic [2:0] OpFill   = 3'd0;
  localparam logic [2:0] OpClear  = 3'd1;
  localparam logic [2:0] OpBlitSt = 3'd2;
  localparam logic [2:0] OpBlitDt = 3'd3;
  localparam logic [2:0] OpConv   = 3'd4;
  localparam logic [2:0] OpRead   = 3'd5;

  localparam logic [1:0] StDone   = 2'd0;
  localparam logic [1:0] StReject = 2'd1;
  localparam logic [1:0] StIgnore = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_WR,
    S_RD2,
    S_WR2,
    S_OUT
  } state_e;

  // memory job kinds set by the datapath when an item is loaded
  typedef enum logic [1:0] {
    J_NONE,
    J_FILL,
    J_CONV,
    J_BLIT
  } job_e;

  typedef struct packed {
    logic init;      // clear one store byte after reset
    logic load;      // capture item, decode
    logic rd;        // issue memory read at current address
    logic wr;        // write merged data
    logic step;      // advance walk
    logic second;    // work on second (lower) blit page
    logic out_load;  // register result
  } cmd_t;

  typedef struct packed {
    job_e job;
    logic walk_last; // last byte of fill/convert walk
    logic has_second;
    logic init_last; // last byte of the clearing pass
  } stat_t;

endpackage

@@ rtl/core/pfde_ctrl.sv @@
module pfde_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  input  pfde_pkg::stat_t stat_i,
  output pfde_pkg::cmd_t  cmd_o
);

  pfde_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfde_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfde_pkg::S_INIT: if (stat_i.init_last) state_d = pfde_pkg::S_IDLE;
      pfde_pkg::S_IDLE: if (in_valid_i) state_d = pfde_pkg::S_RD;
      pfde_pkg::S_RD: begin
        unique case (stat_i.job)
          pfde_pkg::J_NONE: state_d = pfde_pkg::S_OUT;
          default:          state_d = pfde_pkg::S_WR;
        endcase
      end
      pfde_pkg::S_WR: begin
        if (stat_i.job == pfde_pkg::J_BLIT) begin
          state_d = stat_i.has_second ? pfde_pkg::S_RD2 : pfde_pkg::S_OUT;
        end else if (stat_i.walk_last) begin
          state_d = pfde_pkg::S_OUT;
        end else begin
          state_d = pfde_pkg::S_RD;
        end
      end
      pfde_pkg::S_RD2: state_d = pfde_pkg::S_WR2;
      pfde_pkg::S_WR2: state_d = pfde_pkg::S_OUT;
      pfde_pkg::S_OUT: if (!out_busy_i) state_d = pfde_pkg::S_IDLE;
      default: state_d = pfde_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pfde_pkg::S_INIT: cmd_o.init = 1'b1;
      pfde_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      pfde_pkg::S_RD:  cmd_o.rd = 1'b1;
      pfde_pkg::S_WR: begin
        cmd_o.wr   = 1'b1;
        // a two-page blit byte advances after its lower page
        cmd_o.step = !(stat_i.job == pfde_pkg::J_BLIT && stat_i.has_second);
      end
      pfde_pkg::S_RD2: begin
        cmd_o.rd     = 1'b1;
        cmd_o.second = 1'b1;
      end
      pfde_pkg::S_WR2: begin
        cmd_o.wr     = 1'b1;
        cmd_o.second = 1'b1;
        cmd_o.step   = 1'b1;
      end
      pfde_pkg::S_OUT: cmd_o.out_load = !out_busy_i;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/pfde_dp.sv @@
module pfde_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfde_pkg::cmd_t  cmd_i,
  output pfde_pkg::stat_t stat_o,
  input  logic [2:0]      operation_i,
  input  logic [7:0]      x_pos_i,
  input  logic [7:0]      y_pos_i,
  input  logic [7:0]      rect_width_i,
  input  logic [7:0]      rect_height_i,
  input  logic [7:0]      data_byte_i,
  input  logic [63:0]     rows_packed_i,
  input  logic [3:0]      page_i,
  input  logic [3:0]      column_group_i,
  output logic [1:0]      status_o,
  output logic [7:0]      read_data_o,
  output logic            blit_finished_o
);

  localparam int unsigned PW = pfde_pkg::PageW;
  localparam int unsigned CW = pfde_pkg::ColW;
  localparam int unsigned AW = pfde_pkg::AddrW;

  logic [7:0] mem_q [pfde_pkg::StoreSize];
  logic [7:0] rdata_q;
  logic [AW-1:0] init_cnt_q, init_cnt_d;

  pfde_pkg::job_e job_q, job_d;
  logic [1:0]     status_q, status_d;
  logic           fin_q, fin_d;
  logic           is_read_q, is_read_d;
  logic           clear_q, clear_d;
  // walk state for fill/convert
  logic [PW-1:0]  pg_q, pg_d;
  logic [PW-1:0]  pg_end_q, pg_end_d;
  logic [CW:0]    col_q, col_d;
  logic [CW:0]    col_lo_q, col_lo_d;
  logic [CW:0]    col_end_q, col_end_d;
  logic [8:0]     y_lo_q, y_lo_d;
  logic [8:0]     y_hi_q, y_hi_d;
  logic [63:0]    rows_q, rows_d;
  logic [7:0]     src_q, src_d;
  // blit state
  logic           ba_q, ba_d;
  logic [7:0]     bcol_q, bcol_d;
  logic [7:0]     bleft_q, bleft_d;
  logic [3:0]     bpage_q, bpage_d;
  logic [2:0]     boff_q, boff_d;
  logic [5:0]     bbpc_q, bbpc_d;
  logic [5:0]     bidx_q, bidx_d;

  // store address and write data
  logic [AW-1:0]  addr;
  logic [7:0]     wdata;
  logic           addr_ok;
  logic [8:0]     pgb;
  logic [7:0]     fmask;
  logic [8:0]     ptop, pbot;
  logic [3:0]     lo_b, hi_b;
  logic [7:0]     cvt;
  logic [2:0]     cidx;
  logic [7:0]     bm;

  always_comb begin
    init_cnt_d = init_cnt_q + AW'(1);
    pgb   = {5'd0, bpage_q} + {3'd0, bidx_q} + {8'd0, cmd_i.second};
    bm    = 8'hFF << boff_q;
    ptop  = {{(9-PW-3){1'b0}}, pg_q, 3'b000};
    pbot  = ptop + 9'd8;
    lo_b  = (y_lo_q > ptop) ? 4'(y_lo_q - ptop) : 4'd0;
    hi_b  = (y_hi_q < pbot) ? 4'(y_hi_q - ptop) : 4'd8;
    fmask = 8'((9'h1FF >> (4'd9 - hi_b)) & ~((9'h1 << lo_b) - 9'h1));
    cidx  = col_q[2:0];
    for (int n = 0; n < 8; n++) begin
      cvt[7-n] = rows_q[8*n + 7 - cidx];
    end
    addr_ok = 1'b1;
    wdata   = rdata_q;
    unique case (job_q)
      pfde_pkg::J_BLIT: begin
        addr_ok = (pgb * pfde_pkg::ScreenWidth + {1'b0, bcol_q})
                  < pfde_pkg::StoreSize;
        addr    = AW'(pgb * pfde_pkg::ScreenWidth + {1'b0, bcol_q});
        if (cmd_i.second) begin
          wdata = (rdata_q & bm) | 8'(src_q >> (4'd8 - {1'b0, boff_q}));
        end else begin
          wdata = (rdata_q & ~bm) | 8'(src_q << boff_q);
        end
      end
      pfde_pkg::J_CONV: begin
        addr  = AW'(pg_q * pfde_pkg::ScreenWidth + col_q[CW-1:0]);
        wdata = cvt;
      end
      default: begin
        addr  = AW'(pg_q * pfde_pkg::ScreenWidth + col_q[CW-1:0]);
        wdata = clear_q ? (rdata_q & ~fmask) : (rdata_q | fmask);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rdata_q <= mem_q[addr];
    if (cmd_i.init) begin
      mem_q[init_cnt_q] <= 8'd0;
    end else if (cmd_i.wr && addr_ok) begin
      mem_q[addr] <= wdata;
    end
  end

  always_comb begin
    stat_o.job        = job_q;
    stat_o.walk_last  = (col_q + 1'b1 >= col_end_q) && (pg_q == pg_end_q);
    stat_o.has_second = boff_q != 3'd0;
    stat_o.init_last  = init_cnt_q == AW'(pfde_pkg::StoreSize - 1);
  end

  always_comb begin
    job_d = job_q; status_d = status_q; fin_d = fin_q;
    is_read_d = is_read_q; clear_d = clear_q;
    pg_d = pg_q; pg_end_d = pg_end_q; col_d = col_q; col_lo_d = col_lo_q;
    col_end_d = col_end_q; y_lo_d = y_lo_q; y_hi_d = y_hi_q;
    rows_d = rows_q; src_d = src_q;
    ba_d = ba_q; bcol_d = bcol_q; bleft_d = bleft_q; bpage_d = bpage_q;
    boff_d = boff_q; bbpc_d = bbpc_q; bidx_d = bidx_q;
    if (cmd_i.load) begin
      job_d = pfde_pkg::J_NONE; status_d = pfde_pkg::StIgnore;
      fin_d = 1'b0; is_read_d = 1'b0;
      clear_d = operation_i == pfde_pkg::OpClear;
      rows_d = rows_packed_i; src_d = data_byte_i;
      unique case (operation_i)
        pfde_pkg::OpFill, pfde_pkg::OpClear: begin
          if ({1'b0, x_pos_i} >= 9'(pfde_pkg::ScreenWidth)
              || {1'b0, y_pos_i} >= 9'(pfde_pkg::ScreenHeight)) begin
            status_d = pfde_pkg::StReject;
          end else begin
            status_d = pfde_pkg::StDone;
            col_lo_d = (CW+1)'(x_pos_i);
            col_d    = (CW+1)'(x_pos_i);
            col_end_d = ({1'b0, x_pos_i} + {1'b0, rect_width_i}
                         > 9'(pfde_pkg::ScreenWidth)) ? (CW+1)'(pfde_pkg::ScreenWidth)
                        : (CW+1)'({1'b0, x_pos_i} + {1'b0, rect_width_i});
            y_lo_d = {1'b0, y_pos_i};
            y_hi_d = ({1'b0, y_pos_i} + {1'b0, rect_height_i}
                      > 9'(pfde_pkg::ScreenHeight)) ? 9'(pfde_pkg::ScreenHeight)
                     : {1'b0, y_pos_i} + {1'b0, rect_height_i};
            pg_d = PW'(y_pos_i[7:3]);
            pg_end_d = PW'((y_hi_d - 9'd1) >> 3);
            if (rect_width_i != 0 && rect_height_i != 0) job_d = pfde_pkg::J_FILL;
          end
        end
        pfde_pkg::OpBlitSt: begin
          if ({1'b0, x_pos_i} + {1'b0, rect_width_i} > 9'(pfde_pkg::ScreenWidth)
              || {1'b0, y_pos_i} + {1'b0, rect_height_i}
                 > 9'(pfde_pkg::ScreenHeight)
              || {1'b0, x_pos_i} >= 9'(pfde_pkg::ScreenWidth)
              || {1'b0, y_pos_i} >= 9'(pfde_pkg::ScreenHeight)) begin
            status_d = pfde_pkg::StReject;
            ba_d = 1'b0; bcol_d = '0; bleft_d = '0; bidx_d = '0;
          end else begin
            status_d = pfde_pkg::StDone;
            bcol_d  = x_pos_i;
            bpage_d = y_pos_i[6:3];
            boff_d  = y_pos_i[2:0];
            bbpc_d  = 6'(({1'b0, rect_height_i} + 9'd7) >> 3);
            bidx_d  = '0;
            ba_d    = rect_height_i != 0;
            bleft_d = (rect_height_i == 0) ? 8'd0
                      : (rect_width_i == 0) ? 8'd1 : rect_width_i;
          end
        end
        pfde_pkg::OpBlitDt: begin
          if (ba_q) begin
            status_d = pfde_pkg::StDone;
            job_d = pfde_pkg::J_BLIT;
          end
        end
        pfde_pkg::OpConv: begin
          if ({1'b0, page_i} >= 5'(pfde_pkg::PageCount)
              || {1'b0, column_group_i} >= 5'(pfde_pkg::ScreenWidth / 8)) begin
            status_d = pfde_pkg::StReject;
          end else begin
            status_d  = pfde_pkg::StDone;
            job_d     = pfde_pkg::J_CONV;
            pg_d      = PW'(page_i);
            pg_end_d  = PW'(page_i);
            col_d     = (CW+1)'({column_group_i, 3'b000});
            col_end_d = (CW+1)'({1'b0, column_group_i, 3'b000} + 8'd8);
          end
        end
        pfde_pkg::OpRead: begin
          if ({1'b0, x_pos_i} < 9'(pfde_pkg::ScreenWidth)
              && {1'b0, page_i} <= 5'(pfde_pkg::PageCount)) begin
            status_d  = pfde_pkg::StDone;
            is_read_d = 1'b1;
            pg_d      = PW'(page_i);
            col_d     = (CW+1)'(x_pos_i);
          end else begin
            status_d = pfde_pkg::StReject;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.step) begin
      unique case (job_q)
        pfde_pkg::J_BLIT: begin
          if (bidx_q + 6'd1 >= bbpc_q) begin
            bidx_d = '0;
            bcol_d = bcol_q + 8'd1;
            bleft_d = bleft_q - 8'd1;
            if (bleft_q == 8'd1) begin
              ba_d = 1'b0; bcol_d = '0; fin_d = 1'b1;
            end
          end else begin
            bidx_d = bidx_q + 6'd1;
          end
        end
        default: begin
          if (col_q + 1'b1 >= col_end_q) begin
            col_d = (job_q == pfde_pkg::J_CONV) ? col_q : col_lo_q;
            pg_d  = pg_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q <= pfde_pkg::J_NONE;
      init_cnt_q <= '0;
      ba_q <= 1'b0; bcol_q <= '0; bleft_q <= '0; bpage_q <= '0;
      boff_q <= '0; bbpc_q <= '0; bidx_q <= '0;
    end else begin
      job_q <= job_d;
      if (cmd_i.init) init_cnt_q <= init_cnt_d;
      ba_q <= ba_d; bleft_q <= bleft_d; bpage_q <= bpage_d;
      boff_q <= boff_d; bbpc_q <= bbpc_d;
      bidx_q <= bidx_d;
      bcol_q <= bcol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d; fin_q <= fin_d; is_read_q <= is_read_d;
    clear_q <= clear_d; pg_q <= pg_d; pg_end_q <= pg_end_d; col_q <= col_d;
    col_lo_q <= col_lo_d; col_end_q <= col_end_d; y_lo_q <= y_lo_d;
    y_hi_q <= y_hi_d; rows_q <= rows_d; src_q <= src_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_o <= pfde_pkg::StIgnore; read_data_o <= '0; blit_finished_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      status_o        <= status_q;
      read_data_o     <= is_read_q ? rdata_q : 8'd0;
      blit_finished_o <= fin_q;
    end
  end

endmodule

@@ rtl/core/page_framebuffer_draw_engine_core.sv @@
// Page-mode 1-bit frame store with drawing engine, one result per transaction.
// After reset all 1152 store bytes are cleared to zero, one byte per cycle,
// with the input held off. Each accepted transaction runs through its own
// steps: read, blit start, rejected, ignored and empty fill items do one store
// read and then give their result; a blit data byte does a read-modify-write
// of its page, or of each of the two pages it spans, through the single store
// port; fill and clear do a read-modify-write of each covered page byte, and
// convert of its eight column bytes. A result not taken holds the input off.
module page_framebuffer_draw_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // operation[2:0] x_pos[10:3] y_pos[18:11] rect_width[26:19] rect_height[34:27]
  // data_byte[42:35] rows_packed[106:43] page[110:107] column_group[114:111]
  input  logic [119:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0] read_data[9:2] blit_finished[10]
  output logic [15:0] m_axis_tdata_o
);

  pfde_pkg::cmd_t  cmd;
  pfde_pkg::stat_t stat;
  logic            ovalid_q;
  logic [1:0]      status;
  logic [7:0]      rdata;
  logic            fin;

  pfde_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_busy_i (ovalid_q && !m_axis_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfde_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i          (cmd),
    .stat_o         (stat),
    .operation_i    (s_axis_tdata_i[2:0]),
    .x_pos_i        (s_axis_tdata_i[10:3]),
    .y_pos_i        (s_axis_tdata_i[18:11]),
    .rect_width_i   (s_axis_tdata_i[26:19]),
    .rect_height_i  (s_axis_tdata_i[34:27]),
    .data_byte_i    (s_axis_tdata_i[42:35]),
    .rows_packed_i  (s_axis_tdata_i[106:43]),
    .page_i         (s_axis_tdata_i[110:107]),
    .column_group_i (s_axis_tdata_i[114:111]),
    .status_o       (status),
    .read_data_o    (rdata),
    .blit_finished_o(fin)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {5'd0, fin, rdata, status};

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready_i |=> ovalid_q) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> !s_axis_tready_o) else $error("accept during work");
`endif

endmodule
